[rtl/interrupt_livelock_limiter_core_macros.svh]
// ---------------------------------------------------------------------------
// interrupt livelock limiter assertion macros
// shared property forms for the port checker, clocked on aclk and
// disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef INTERRUPT_LIVELOCK_LIMITER_CORE_MACROS_SVH
`define INTERRUPT_LIVELOCK_LIMITER_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ILL_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ILL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ill_pkg.sv]
// ---------------------------------------------------------------------------
// ill_pkg
// shared widths, register indexes, constants and the controller/datapath
// command and status types of the interrupt livelock limiter
// ---------------------------------------------------------------------------
package ill_pkg;

    localparam int LINE_W     = 5;
    localparam int STAMP_W    = 32;
    localparam int WIN_W      = 33;
    localparam int RCFG_W     = 20;
    localparam int DELAY_W    = 19;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_FREQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_RATE = 2'd2;

    localparam logic [31:0]        TIMER_FREQ_RESET = 32'd1193182;
    localparam logic [RCFG_W-1:0]  RATE_LIMIT_RESET = 20'd50000;
    localparam logic [RCFG_W-1:0]  FALLBACK_RESET   = 20'd20000;
    localparam logic [31:0]        US_PER_SEC       = 32'd1000000;
    localparam logic [DELAY_W-1:0] MAX_DELAY        = 19'd500001;
    localparam logic [DELAY_W-1:0] DELAY_RESET      =
        19'(32'd1 + US_PER_SEC / 32'(FALLBACK_RESET));

    localparam logic STATE_NORMAL  = 1'b0;
    localparam logic STATE_LIMITED = 1'b1;

    typedef struct packed {
        logic               lim;
        logic [WIN_W-1:0]   win;
        logic [STAMP_W-1:0] last;
        logic [31:0]        cnt;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic cfg_wr;
        logic load;
        logic add;
        logic mul;
        logic div_start;
        logic div_delay;
        logic close;
        logic write_out;
        logic dly_done;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic close_due;
        logic div_done;
        logic entered;
        logic out_free;
        logic dly_stale;
    } stat_t;

endpackage

[rtl/interrupt_livelock_limiter_core.sv]
// ---------------------------------------------------------------------------
// interrupt_livelock_limiter_core
// per-line interrupt rate measurement with a limited state and rearm delay
// ---------------------------------------------------------------------------
// One service pass is taken at a time. A pass that closes a measurement window
// uses the radix-2 divider, which forms count*frequency/ticks one quotient bit
// per cycle; a pass that enters limited state at a timer frequency below 4 may
// close two windows. A write to fallback_rate recomputes the rearm delay in the
// same divider, holding s_tready and cfg_ready low until it is done. The next
// item is taken while a result still waits in the output register.
module interrupt_livelock_limiter_core #(
    parameter int NUM_LINES = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ill_pkg::S_DATA_W-1:0]   s_tdata,   // line[4:0], now_ticks[36:5]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ill_pkg::M_DATA_W-1:0]   m_tdata,   // line_out[4:0], limited[5],
                                                      // rearm_delay_us[24:6],
                                                      // entered_limit[25], left_limit[26],
                                                      // rate_valid[27], measured_rate[59:28]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ill_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ill_pkg::CFG_DATA_W-1:0] cfg_data
);

    ill_pkg::cmd_t  cmd;
    ill_pkg::stat_t stat;

    ill_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ill_dp #(
        .NUM_LINES (NUM_LINES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/ill_div.sv]
// ---------------------------------------------------------------------------
// ill_div
// radix-2 restoring divider, one quotient bit per cycle; the upper dividend
// word must be below the divisor, giving a 32-bit quotient
// ---------------------------------------------------------------------------
module ill_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num_hi,
    input  logic [31:0] num_lo,
    input  logic [32:0] den,
    output logic        done,
    output logic [31:0] quot
);

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [32:0] den_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [33:0] trial;
    logic        ge;
    logic [32:0] rem_next;
    logic [31:0] quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[31]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
        quo_next = {quo_reg[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num_hi};
            quo_reg <= num_lo;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/ill_dp.sv]
// ---------------------------------------------------------------------------
// ill_dp
// datapath: configuration registers, per-line state memory, window
// arithmetic, shared divider and the output register
// ---------------------------------------------------------------------------
module ill_dp #(
    parameter int NUM_LINES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ill_pkg::cmd_t                    cmd,
    output ill_pkg::stat_t                   stat,
    input  logic [ill_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [ill_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ill_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ill_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int IDXW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // configuration
    logic [31:0]                    freq_reg;
    logic [ill_pkg::RCFG_W-1:0]     limit_reg;
    logic [ill_pkg::RCFG_W-1:0]     fb_reg;
    logic                           stale_reg;
    logic [ill_pkg::DELAY_W-1:0]    delay_reg;

    // state memory
    ill_pkg::entry_t                mem [NUM_LINES];
    logic [NUM_LINES-1:0]           vld_reg;
    ill_pkg::entry_t                rd_reg;
    logic                           rdv_reg;

    // item under work
    logic [ill_pkg::LINE_W-1:0]     line_reg;
    logic [31:0]                    now_reg;
    logic                           inr_reg;
    logic [IDXW-1:0]                idx_reg;
    logic [31:0]                    cnt_reg;
    logic [ill_pkg::WIN_W-1:0]      win_reg;
    logic [31:0]                    el_reg;
    logic                           lim_reg;
    logic                           ran_reg;
    logic                           ent_reg;
    logic                           left_reg;
    logic                           val_reg;
    logic [31:0]                    rate_reg;
    logic [63:0]                    prod_reg;
    logic                           sat_reg;

    // output register
    logic                           out_valid_reg;
    logic [ill_pkg::M_DATA_W-1:0]   out_data_reg;

    logic [ill_pkg::LINE_W-1:0]     line_in;
    logic [31:0]                    now_in;
    logic                           inr_in;
    logic [IDXW-1:0]                idx_in;
    ill_pkg::entry_t                base;
    ill_pkg::entry_t                wr_entry;
    logic [31:0]                    el_raw;
    logic [31:0]                    el_clamp;
    logic [ill_pkg::WIN_W-1:0]      frame;
    logic [63:0]                    prod_w;
    logic [31:0]                    div_hi;
    logic [31:0]                    div_lo;
    logic [32:0]                    div_den;
    logic                           div_done;
    logic [31:0]                    div_q;
    logic [31:0]                    rate_w;
    logic [ill_pkg::DELAY_W-1:0]    delay_new;
    logic [ill_pkg::DELAY_W-1:0]    delay_out;

    always_comb begin
        line_in   = s_tdata[4:0];
        now_in    = s_tdata[36:5];
        inr_in    = 32'(line_in) < 32'(NUM_LINES);
        idx_in    = IDXW'(line_in);
        base      = rdv_reg ? rd_reg : '0;
        el_raw    = now_reg - base.last;
        el_clamp  = (el_raw > freq_reg) ? freq_reg : el_raw;
        frame     = {3'b000, freq_reg[31:2]};
        prod_w    = cnt_reg * freq_reg;
        if (cmd.div_delay) begin
            div_hi  = '0;
            div_lo  = ill_pkg::US_PER_SEC;
            div_den = {13'd0, fb_reg};
        end else begin
            div_hi  = prod_reg[63:32];
            div_lo  = prod_reg[31:0];
            div_den = win_reg;
        end
        rate_w    = sat_reg ? '1 : div_q;
        delay_new = (fb_reg < 20'd2) ? ill_pkg::MAX_DELAY : div_q[18:0] + 19'd1;
        delay_out = ran_reg ? delay_reg : '0;
        wr_entry  = '{lim: lim_reg, win: win_reg, last: now_reg, cnt: cnt_reg};
    end

    ill_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg      <= ill_pkg::TIMER_FREQ_RESET;
            limit_reg     <= ill_pkg::RATE_LIMIT_RESET;
            fb_reg        <= ill_pkg::FALLBACK_RESET;
            stale_reg     <= 1'b0;
            delay_reg     <= ill_pkg::DELAY_RESET;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cfg_wr) begin
                unique case (cfg_index)
                    ill_pkg::REG_TIMER_FREQ:    freq_reg <= cfg_data;
                    ill_pkg::REG_RATE_LIMIT:    limit_reg <= cfg_data[19:0];
                    ill_pkg::REG_FALLBACK_RATE: begin
                        fb_reg    <= cfg_data[19:0];
                        stale_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.dly_done) begin
                delay_reg <= delay_new;
                stale_reg <= 1'b0;
            end
            if (cmd.write_out && inr_reg) begin
                vld_reg[idx_reg] <= 1'b1;
            end
            if (cmd.write_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.accept && inr_in) begin
            rd_reg  <= mem[idx_in];
            rdv_reg <= vld_reg[idx_in];
        end
        if (cmd.write_out && inr_reg) begin
            mem[idx_reg] <= wr_entry;
        end
    end

    // window arithmetic
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            line_reg <= line_in;
            now_reg  <= now_in;
            inr_reg  <= inr_in;
            idx_reg  <= idx_in;
        end
        if (cmd.load) begin
            cnt_reg  <= base.cnt + 32'd1;
            win_reg  <= base.win;
            el_reg   <= el_clamp;
            lim_reg  <= inr_reg & base.lim;
            ran_reg  <= inr_reg & base.lim;
            ent_reg  <= 1'b0;
            left_reg <= 1'b0;
            val_reg  <= 1'b0;
            rate_reg <= '0;
        end
        if (cmd.add) begin
            win_reg <= win_reg + {1'b0, el_reg};
        end
        if (cmd.mul) begin
            prod_reg <= prod_w;
        end
        if (cmd.div_start && !cmd.div_delay) begin
            sat_reg <= {1'b0, prod_reg[63:32]} >= win_reg;
        end
        if (cmd.close) begin
            val_reg  <= 1'b1;
            rate_reg <= rate_w;
            win_reg  <= '0;
            cnt_reg  <= '0;
            if (!ran_reg) begin
                if (rate_w >= {12'd0, limit_reg}) begin
                    lim_reg <= ill_pkg::STATE_LIMITED;
                    ent_reg <= 1'b1;
                    ran_reg <= 1'b1;
                    el_reg  <= '0;
                end
            end else if (rate_w < {13'd0, fb_reg[19:1]}) begin
                lim_reg  <= ill_pkg::STATE_NORMAL;
                left_reg <= 1'b1;
            end
        end
        if (cmd.write_out) begin
            out_data_reg <= {4'd0, (val_reg ? rate_reg : 32'd0), val_reg, left_reg,
                             ent_reg, delay_out, lim_reg, line_reg};
        end
    end

    always_comb begin
        stat.in_range  = inr_reg;
        stat.close_due = win_reg >= frame;
        stat.div_done  = div_done;
        stat.entered   = ent_reg;
        stat.out_free  = !out_valid_reg || m_tready;
        stat.dly_stale = stale_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/ill_ctrl.sv]
// ---------------------------------------------------------------------------
// ill_ctrl
// sequencer for one service pass: load, window update, rate measurement,
// state decision and write-back; also refreshes the rearm delay
// ---------------------------------------------------------------------------
module ill_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  ill_pkg::stat_t stat,
    output ill_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ADD,
        S_CHECK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_CLOSE,
        S_NEXT,
        S_WRITE,
        S_YSTART,
        S_YWAIT,
        S_YDONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        second_next = second_reg;
        s_tready    = (state_reg == S_IDLE) && !stat.dly_stale;
        cfg_ready   = (state_reg == S_IDLE) && !stat.dly_stale;
        cmd.accept  = s_tvalid && s_tready;
        cmd.cfg_wr  = cfg_valid && cfg_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (stat.dly_stale) begin
                    state_next = S_YSTART;
                end else if (cmd.accept) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load    = 1'b1;
                second_next = 1'b0;
                state_next  = stat.in_range ? S_ADD : S_WRITE;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = stat.close_due ? S_MUL : S_WRITE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (stat.div_done) begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE: begin
                cmd.close  = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                // entering pass runs once more as a limited pass
                if (stat.entered && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = S_ADD;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (stat.out_free) begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_YSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_delay = 1'b1;
                state_next    = S_YWAIT;
            end
            S_YWAIT: begin
                cmd.div_delay = 1'b1;
                if (stat.div_done) begin
                    state_next = S_YDONE;
                end
            end
            S_YDONE: begin
                cmd.div_delay = 1'b1;
                cmd.dly_done  = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

[rtl/ill_checker.sv]
// ---------------------------------------------------------------------------
// ill_checker
// port-level checks on result items of the livelock limiter, bound to the
// top level
// ---------------------------------------------------------------------------
`include "interrupt_livelock_limiter_core_macros.svh"

module ill_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ill_pkg::M_DATA_W-1:0] m_tdata
);

    `ILL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")
    `ILL_ASSERT_SAME(a_rate_gated, m_tvalid && !m_tdata[27], m_tdata[59:28] == 32'd0, "rate without closed window")
    `ILL_ASSERT_SAME(a_enter, m_tvalid && m_tdata[25], m_tdata[5] && m_tdata[27] && !m_tdata[26], "bad entering item")
    `ILL_ASSERT_SAME(a_leave, m_tvalid && m_tdata[26], !m_tdata[5] && m_tdata[27] && (m_tdata[24:6] != 19'd0), "bad leaving item")
    `ILL_ASSERT_SAME(a_limited_delay, m_tvalid && m_tdata[5], m_tdata[24:6] != 19'd0, "limited item without delay")

endmodule

bind interrupt_livelock_limiter_core ill_checker u_ill_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
